// ===== rtl/generation_tagged_vertex_cache_macros.svh =====
// Assertion helpers for the vertex cache
`ifndef GENERATION_TAGGED_VERTEX_CACHE_MACROS_SVH
`define GENERATION_TAGGED_VERTEX_CACHE_MACROS_SVH
// Assert that a condition implies a consequence in the same cycle
`define GTVC_ASSERT_IMPL(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle
`define GTVC_ASSERT_NEXT(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/gtvc_pkg.sv =====
package gtvc_pkg;
    localparam int COORD_BITS_DEF = 8;
    localparam logic [30:0] GEN_MAX = 31'h7FFF_FFFF;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_FAIL  = 2'd2,
        OP_FAIL2 = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        SES_IDLE    = 2'd0,
        SES_WRITING = 2'd1,
        SES_READING = 2'd2,
        SES_FAILED  = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        ST_HIT     = 4'd0,
        ST_EMPTY   = 4'd1,
        ST_STALE   = 4'd2,
        ST_AMBIG   = 4'd3,
        ST_RANGE   = 4'd4,
        ST_FAILED  = 4'd5,
        ST_WRITTEN = 4'd6,
        ST_SAME    = 4'd7,
        ST_MARKED  = 4'd8
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clear_we;
        logic take;
        logic look;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
    } t_stat;

    // IEEE single inequality: NaN differs from everything, +0 equals -0
    function automatic logic f_differ(input logic [31:0] a, input logic [31:0] b);
        logic a_nan;
        logic b_nan;
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        if (a_nan || b_nan) begin
            return 1'b1;
        end
        if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
            return 1'b0;
        end
        return a != b;
    endfunction
endpackage

// ===== rtl/gtvc_in_if.sv =====
interface gtvc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic [31:0] vertex_x;
    logic [31:0] vertex_y;
    logic [31:0] vertex_z;
    modport source (output valid, opcode, screen_x, screen_y, vertex_x, vertex_y, vertex_z,
                    input ready);
    modport sink (input valid, opcode, screen_x, screen_y, vertex_x, vertex_y, vertex_z,
                  output ready);
endinterface

// ===== rtl/gtvc_out_if.sv =====
interface gtvc_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [31:0] found_x;
    logic [31:0] found_y;
    logic [31:0] found_z;
    modport source (output valid, status, found_x, found_y, found_z, input ready);
    modport sink (input valid, status, found_x, found_y, found_z, output ready);
endinterface

// ===== rtl/gtvc_ram.sv =====
module gtvc_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/gtvc_ctrl.sv =====
module gtvc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_ready,
    input  gtvc_pkg::t_stat i_stat,
    output gtvc_pkg::t_cmd  o_cmd,
    output logic          o_in_ready,
    output logic          o_out_valid
);
    import gtvc_pkg::*;

    t_state r_state;
    t_state n_state;

    // advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (i_stat.clear_last) n_state = S_IDLE;
            S_IDLE:  if (i_in_valid) n_state = S_LOOK;
            S_LOOK:  n_state = S_OUT;
            S_OUT:   if (i_out_ready) n_state = i_in_valid ? S_LOOK : S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_CLEAR: o_cmd.clear_we = 1'b1;
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            S_LOOK: o_cmd.look = 1'b1;
            S_OUT: begin
                o_out_valid = 1'b1;
                o_in_ready = i_out_ready;
                o_cmd.take = i_out_ready && i_in_valid;
            end
            default: ;
        endcase
    end
endmodule

// ===== rtl/gtvc_dp.sv =====
module gtvc_dp #(
    parameter int COORD_BITS = gtvc_pkg::COORD_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  gtvc_pkg::t_cmd  i_cmd,
    output gtvc_pkg::t_stat o_stat,
    input  logic [1:0]    i_opcode,
    input  logic [15:0]   i_screen_x,
    input  logic [15:0]   i_screen_y,
    input  logic [31:0]   i_vertex_x,
    input  logic [31:0]   i_vertex_y,
    input  logic [31:0]   i_vertex_z,
    output logic [3:0]    o_status,
    output logic [31:0]   o_found_x,
    output logic [31:0]   o_found_y,
    output logic [31:0]   o_found_z
);
    import gtvc_pkg::*;

    localparam int AW = 2 * COORD_BITS;
    localparam int DEPTH = 1 << AW;

    logic [AW-1:0] r_clr;
    logic [1:0]    r_op;
    logic [AW-1:0] r_idx;
    logic          r_inr;
    logic [95:0]   r_vtx;
    t_mode         r_mode;
    logic [30:0]   r_gen;
    logic [127:0]  w_rd;
    logic          w_inr;
    logic [AW-1:0] w_idx;
    logic [COORD_BITS-1:0] w_xi;
    logic [COORD_BITS-1:0] w_yi;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [127:0]  w_wdata;
    logic [3:0]    w_st;
    logic [31:0]   w_tag;
    logic          w_dif;
    logic [30:0]   w_gen_use;

    // range check: upper bits must all copy the sign at bit COORD_BITS-1
    always_comb begin
        w_inr = ((i_screen_x[15:COORD_BITS-1] == '0) || (i_screen_x[15:COORD_BITS-1] == '1)) &&
                ((i_screen_y[15:COORD_BITS-1] == '0) || (i_screen_y[15:COORD_BITS-1] == '1));
        w_xi = {~i_screen_x[COORD_BITS-1], i_screen_x[COORD_BITS-2:0]};
        w_yi = {~i_screen_y[COORD_BITS-1], i_screen_y[COORD_BITS-2:0]};
        w_idx = {w_yi, w_xi};
    end

    // hold the item and sweep the clear counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clear_we) begin
            r_clr <= r_clr + 1'b1;
        end
        if (i_cmd.take) begin
            r_op <= i_opcode;
            r_idx <= w_idx;
            r_inr <= w_inr;
            r_vtx <= {i_vertex_z, i_vertex_y, i_vertex_x};
        end
    end
    assign o_stat.clear_last = (r_clr == AW'(DEPTH - 1));

    gtvc_ram #(.WIDTH(128), .DEPTH(DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_idx), .o_rdata(w_rd)
    );

    // decide the result and the cell update
    always_comb begin
        w_tag = w_rd[127:96];
        w_gen_use = r_gen;
        if ((r_op == OP_WRITE) && (r_mode != SES_WRITING) && (r_gen != GEN_MAX)) begin
            w_gen_use = r_gen + 31'd1;
        end
        w_dif = f_differ(w_rd[31:0], r_vtx[31:0]) || f_differ(w_rd[63:32], r_vtx[63:32]) ||
                f_differ(w_rd[95:64], r_vtx[95:64]);
        w_we = 1'b0;
        w_waddr = r_idx;
        w_wdata = w_rd;
        w_st = ST_FAILED;
        if (i_cmd.clear_we) begin
            w_we = 1'b1;
            w_waddr = r_clr;
            w_wdata = '0;
        end else if (r_op == OP_WRITE) begin
            if (!r_inr) begin
                w_st = ST_RANGE;
            end else if (w_tag[31:1] == w_gen_use) begin
                if (w_dif) begin
                    w_st = ST_MARKED;
                    w_wdata[96] = 1'b1;
                    w_we = i_cmd.look;
                end else begin
                    w_st = ST_SAME;
                end
            end else begin
                w_st = ST_WRITTEN;
                w_wdata = {w_gen_use, 1'b0, r_vtx};
                w_we = i_cmd.look;
            end
        end else if (r_op == OP_READ) begin
            if (r_mode == SES_FAILED) w_st = ST_FAILED;
            else if (!r_inr) w_st = ST_RANGE;
            else if (w_tag == 32'd0) w_st = ST_EMPTY;
            else if (w_tag[31:1] != r_gen) w_st = ST_STALE;
            else if (w_tag[0]) w_st = ST_AMBIG;
            else w_st = ST_HIT;
        end
    end

    // update mode and generation, load the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= SES_IDLE;
            r_gen <= 31'd1;
        end else if (i_cmd.look) begin
            r_gen <= w_gen_use;
            if (r_op == OP_WRITE) r_mode <= SES_WRITING;
            else if (r_op == OP_READ) begin
                r_mode <= (r_mode == SES_FAILED) ? SES_FAILED : SES_READING;
            end
            else r_mode <= SES_FAILED;
        end
        if (i_cmd.look) begin
            o_status <= w_st;
            o_found_x <= (w_st == ST_HIT && r_op == OP_READ) ? w_rd[31:0] : 32'd0;
            o_found_y <= (w_st == ST_HIT && r_op == OP_READ) ? w_rd[63:32] : 32'd0;
            o_found_z <= (w_st == ST_HIT && r_op == OP_READ) ? w_rd[95:64] : 32'd0;
        end
    end
endmodule

// ===== rtl/generation_tagged_vertex_cache.sv =====
// Vertex cache keyed by signed screen position with generation tags. After reset
// the store is cleared, one cell a cycle, during which no item is taken. Each item
// is then looked up with one synchronous read of its cell; a write that changes
// the cell writes it back on the single RAM port pair. The result is held in an
// output register; the next item is taken in the cycle that result is delivered.
module generation_tagged_vertex_cache #(
    parameter int COORD_BITS = gtvc_pkg::COORD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    gtvc_in_if.sink   i_in,
    gtvc_out_if.source o_out
);
    import gtvc_pkg::*;
`include "generation_tagged_vertex_cache_macros.svh"

    t_cmd  w_cmd;
    t_stat w_stat;

    gtvc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in.valid),
        .i_out_ready(o_out.ready), .i_stat(w_stat), .o_cmd(w_cmd),
        .o_in_ready(i_in.ready), .o_out_valid(o_out.valid)
    );

    gtvc_dp #(.COORD_BITS(COORD_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_stat(w_stat),
        .i_opcode(i_in.opcode), .i_screen_x(i_in.screen_x), .i_screen_y(i_in.screen_y),
        .i_vertex_x(i_in.vertex_x), .i_vertex_y(i_in.vertex_y),
        .i_vertex_z(i_in.vertex_z), .o_status(o_out.status),
        .o_found_x(o_out.found_x), .o_found_y(o_out.found_y), .o_found_z(o_out.found_z)
    );

    `GTVC_ASSERT_NEXT(a_take_then_look, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)
    `GTVC_ASSERT_IMPL(a_found_only_hit, i_clk, i_rst_n,
        o_out.valid && (o_out.status != ST_HIT), o_out.found_x == 32'd0)
    `GTVC_ASSERT_NEXT(a_look_then_out, i_clk, i_rst_n, w_cmd.look, o_out.valid)
endmodule
